// ===== sv/stdma_pkg.sv =====
package stdma_pkg;

  // Fixed address constants of the sprite table copy.
  localparam logic [15:0] SpriteBase   = 16'hFE00;
  localparam logic [7:0]  SpriteLimit  = 8'hA0;
  localparam logic [15:0] MirrorStart  = 16'hE000;
  localparam logic [15:0] MirrorOffset = 16'h2000;

  // Reset values of the configuration registers.
  localparam logic [2:0]  StartupDelayRst      = 3'd1;
  localparam logic [15:0] ExternalLowEndRst    = 16'h7FFF;
  localparam logic [15:0] ExternalHighStartRst = 16'hA000;
  localparam logic [15:0] ExternalHighEndRst   = 16'hFDFF;
  localparam logic [15:0] VideoStartRst        = 16'h8000;
  localparam logic [15:0] VideoEndRst          = 16'h9FFF;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgStartupDelay      = 3'd0,
    CfgExternalLowEnd    = 3'd1,
    CfgExternalHighStart = 3'd2,
    CfgExternalHighEnd   = 3'd3,
    CfgVideoStart        = 3'd4,
    CfgVideoEnd          = 3'd5
  } cfg_idx_e;

  // One machine cycle request.
  typedef struct packed {
    logic        start_request;
    logic [15:0] start_address;
    logic [15:0] cpu_address;
  } in_t;

  // One machine cycle result.
  typedef struct packed {
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [15:0] copy_destination;
    logic        engine_active;
    logic        bus_conflict;
    logic [15:0] cpu_read_address;
  } out_t;

  // Configuration write request.
  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_req_t;

  // Bus range bounds handed to the range decoders.
  typedef struct packed {
    logic [15:0] external_low_end;
    logic [15:0] external_high_start;
    logic [15:0] external_high_end;
    logic [15:0] video_start;
    logic [15:0] video_end;
  } bus_cfg_t;

  // Bus membership of one address.
  typedef struct packed {
    logic on_external;
    logic on_video;
  } bus_hit_t;

endpackage

// ===== sv/stdma_stream_if.sv =====
interface stdma_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/stdma_bus_check.sv =====
module stdma_bus_check (
  input  stdma_pkg::bus_cfg_t bus_cfg_i,
  input  logic [15:0]         addr_i,
  output stdma_pkg::bus_hit_t hit_o
);
  import stdma_pkg::*;

  // Range compares exactly as written; an inverted range matches nothing.
  always_comb begin
    hit_o.on_external = (addr_i <= bus_cfg_i.external_low_end) ||
                        ((bus_cfg_i.external_high_start <= addr_i) &&
                         (addr_i <= bus_cfg_i.external_high_end));
    hit_o.on_video    = (bus_cfg_i.video_start <= addr_i) &&
                        (addr_i <= bus_cfg_i.video_end);
  end

endmodule

// ===== sv/sprite_table_dma_engine.sv =====
// Sprite table DMA engine. Each request is one machine cycle: it may start a
// copy and carries a CPU address that is checked against the DMA source for
// a shared bus. One request is taken every clock unless the result side
// stalls; its result passes an input register and a result register, and the
// input register can take a new request while an earlier result waits to be
// taken. Configuration writes are always ready and take effect at once; they
// should only be issued while no request is in flight.
module sprite_table_dma_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  stdma_stream_if.sink          req_i,
  stdma_stream_if.source        rsp_o,
  stdma_stream_if.sink          cfg_i
);
  import stdma_pkg::*;

  // Configuration registers.
  logic [2:0] startup_delay_q;
  bus_cfg_t   bus_cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_delay_q               <= StartupDelayRst;
      bus_cfg_q.external_low_end    <= ExternalLowEndRst;
      bus_cfg_q.external_high_start <= ExternalHighStartRst;
      bus_cfg_q.external_high_end   <= ExternalHighEndRst;
      bus_cfg_q.video_start         <= VideoStartRst;
      bus_cfg_q.video_end           <= VideoEndRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.data.index))
        CfgStartupDelay:      startup_delay_q <= cfg_i.data.data[2:0];
        CfgExternalLowEnd:    bus_cfg_q.external_low_end <= cfg_i.data.data;
        CfgExternalHighStart: bus_cfg_q.external_high_start <= cfg_i.data.data;
        CfgExternalHighEnd:   bus_cfg_q.external_high_end <= cfg_i.data.data;
        CfgVideoStart:        bus_cfg_q.video_start <= cfg_i.data.data;
        CfgVideoEnd:          bus_cfg_q.video_end <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: input register feeds the result register.
  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  out_t out_q;
  logic out_free;
  logic step;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign step        = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q <= req_i.data;
    end
  end

  // Engine state.
  logic        copy_running_q, copy_running_d;
  logic        start_pending_q, start_pending_d;
  logic [15:0] source_pointer_q, source_pointer_d;
  logic [15:0] pending_address_q, pending_address_d;
  logic [2:0]  startup_count_q, startup_count_d;

  // Bus decode of the CPU address and the DMA source.
  bus_hit_t cpu_hit;
  bus_hit_t src_hit;

  stdma_bus_check u_cpu_check (
    .bus_cfg_i (bus_cfg_q),
    .addr_i    (in_q.cpu_address),
    .hit_o     (cpu_hit)
  );

  stdma_bus_check u_src_check (
    .bus_cfg_i (bus_cfg_q),
    .addr_i    (source_pointer_q),
    .hit_o     (src_hit)
  );

  // One machine cycle: sample conflict, latch a request, copy, count down.
  logic        conflict;
  logic [15:0] pointer_inc;
  out_t        result;

  always_comb begin
    conflict = copy_running_q &&
               ((cpu_hit.on_external && src_hit.on_external) ||
                (cpu_hit.on_video && src_hit.on_video));
    pointer_inc = source_pointer_q + 16'd1;

    result.engine_active    = copy_running_q;
    result.bus_conflict     = conflict;
    result.cpu_read_address = conflict ? source_pointer_q : in_q.cpu_address;
    result.copy_valid       = copy_running_q;
    result.copy_source      = copy_running_q ? source_pointer_q : 16'd0;
    result.copy_destination = copy_running_q ?
                              (SpriteBase | {8'd0, source_pointer_q[7:0]}) : 16'd0;

    start_pending_d   = start_pending_q;
    pending_address_d = pending_address_q;
    startup_count_d   = startup_count_q;
    copy_running_d    = copy_running_q;
    source_pointer_d  = source_pointer_q;

    if (in_q.start_request) begin
      start_pending_d   = 1'b1;
      pending_address_d = in_q.start_address;
      startup_count_d   = startup_delay_q;
    end

    if (copy_running_q) begin
      source_pointer_d = pointer_inc;
      if (pointer_inc[7:0] >= SpriteLimit) begin
        copy_running_d = 1'b0;
      end
    end

    if (start_pending_d) begin
      if (startup_count_d == 3'd0) begin
        start_pending_d  = 1'b0;
        copy_running_d   = 1'b1;
        source_pointer_d = (pending_address_d >= MirrorStart) ?
                           (pending_address_d - MirrorOffset) : pending_address_d;
      end else begin
        startup_count_d = startup_count_d - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_running_q    <= 1'b0;
      start_pending_q   <= 1'b0;
      source_pointer_q  <= 16'd0;
      pending_address_q <= 16'd0;
      startup_count_q   <= 3'd0;
    end else if (step) begin
      copy_running_q    <= copy_running_d;
      start_pending_q   <= start_pending_d;
      source_pointer_q  <= source_pointer_d;
      pending_address_q <= pending_address_d;
      startup_count_q   <= startup_count_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import stdma_pkg::*;

  // Cycle-accurate model of the sprite table copy engine and its result checker.
  class dma_cycle_model;
    logic [2:0]  startup_delay;
    logic [15:0] ext_low_end;
    logic [15:0] ext_high_start;
    logic [15:0] ext_high_end;
    logic [15:0] vid_start;
    logic [15:0] vid_end;
    bit          copy_running;
    bit          start_pending;
    logic [15:0] src_ptr;
    logic [15:0] pend_addr;
    logic [3:0]  countdown;
    out_t        cycle_results_q[$];
    int unsigned mismatch_count;

    function new();
      startup_delay  = StartupDelayRst;
      ext_low_end    = ExternalLowEndRst;
      ext_high_start = ExternalHighStartRst;
      ext_high_end   = ExternalHighEndRst;
      vid_start      = VideoStartRst;
      vid_end        = VideoEndRst;
      copy_running   = 1'b0;
      start_pending  = 1'b0;
      src_ptr        = '0;
      pend_addr      = '0;
      countdown      = '0;
      mismatch_count = 0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        CfgStartupDelay:      startup_delay  = value[2:0];
        CfgExternalLowEnd:    ext_low_end    = value;
        CfgExternalHighStart: ext_high_start = value;
        CfgExternalHighEnd:   ext_high_end   = value;
        CfgVideoStart:        vid_start      = value;
        CfgVideoEnd:          vid_end        = value;
        default: ;
      endcase
    endfunction

    function bit on_external(logic [15:0] addr);
      return addr <= ext_low_end || (ext_high_start <= addr && addr <= ext_high_end);
    endfunction

    function bit on_video(logic [15:0] addr);
      return vid_start <= addr && addr <= vid_end;
    endfunction

    // Advance one machine cycle and queue the result it produces.
    function void take_cycle(in_t req);
      out_t exp;
      bit   hit;
      exp = '0;
      // Bus sharing is judged on the state before this cycle.
      hit = copy_running &&
            ((on_external(req.cpu_address) && on_external(src_ptr)) ||
             (on_video(req.cpu_address) && on_video(src_ptr)));
      exp.engine_active    = copy_running;
      exp.bus_conflict     = hit;
      exp.cpu_read_address = hit ? src_ptr : req.cpu_address;

      // A new start always replaces whatever is pending.
      if (req.start_request) begin
        start_pending = 1'b1;
        pend_addr     = req.start_address;
        countdown     = {1'b0, startup_delay};
      end

      // The running copy moves one byte and stops at the end of the table.
      if (copy_running) begin
        exp.copy_valid       = 1'b1;
        exp.copy_source      = src_ptr;
        exp.copy_destination = SpriteBase | {8'h00, src_ptr[7:0]};
        src_ptr = src_ptr + 16'd1;
        if (src_ptr[7:0] >= SpriteLimit) begin
          copy_running = 1'b0;
        end
      end

      // The startup countdown; at zero the copy (re)starts, mirrored if needed.
      if (start_pending) begin
        if (countdown == 4'd0) begin
          start_pending = 1'b0;
          copy_running  = 1'b1;
          src_ptr = (pend_addr >= MirrorStart) ? pend_addr - MirrorOffset : pend_addr;
        end else begin
          countdown = countdown - 4'd1;
        end
      end
      cycle_results_q.push_back(exp);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch: expected 0x%04h, actual 0x%04h", $time, name, want, seen);
        mismatch_count++;
      end
    endfunction

    function void match_result(out_t got);
      out_t exp;
      if (cycle_results_q.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none, actual %p",
                 $time, got);
        mismatch_count++;
        return;
      end
      exp = cycle_results_q.pop_front();
      compare_field("copy_valid", 16'(exp.copy_valid), 16'(got.copy_valid));
      compare_field("copy_source", exp.copy_source, got.copy_source);
      compare_field("copy_destination", exp.copy_destination, got.copy_destination);
      compare_field("engine_active", 16'(exp.engine_active), 16'(got.engine_active));
      compare_field("bus_conflict", 16'(exp.bus_conflict), 16'(got.bus_conflict));
      compare_field("cpu_read_address", exp.cpu_read_address, got.cpu_read_address);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   sender_gaps;
  bit   receiver_gaps;
  bit   long_hold;

  dma_cycle_model dma_model = new();

  stdma_stream_if #(.T(in_t))     req_if ();
  stdma_stream_if #(.T(out_t))    rsp_if ();
  stdma_stream_if #(.T(cfg_req_t)) cfg_if ();

  sprite_table_dma_engine dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #1_000_000;
    $display("** sprite_table_dma_engine: FAILED **");
    $finish;
  end

  // Result receiver: random stalls, plus one long hold-off on demand.
  initial begin
    rsp_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        rsp_if.ready = 1'b0;
        repeat (80) @(negedge clk);
        long_hold = 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
        rsp_if.ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        rsp_if.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      dma_model.match_result(rsp_if.data);
    end
  end

  // Offer one machine cycle and wait until the request is accepted.
  task automatic send_cycle(logic start_req, logic [15:0] start_addr, logic [15:0] cpu_addr);
    in_t item;
    item.start_request = start_req;
    item.start_address = start_addr;
    item.cpu_address   = cpu_addr;
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.data  = item;
    do @(posedge clk); while (!req_if.ready);
    dma_model.take_cycle(item);
  endtask

  // Stop offering and let every predicted result come out.
  task automatic wait_for_results();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (dma_model.cycle_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [15:0] value);
    cfg_req_t wr;
    wr.index = idx;
    wr.data  = value;
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data  = wr;
    do @(posedge clk); while (!cfg_if.ready);
    dma_model.write_register(idx, value);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic apply_settings(logic [2:0] delay, logic [15:0] lo_end, logic [15:0] hi_start,
                                logic [15:0] hi_end, logic [15:0] v_start,
                                logic [15:0] v_end);
    write_register(CfgStartupDelay, {13'd0, delay});
    write_register(CfgExternalLowEnd, lo_end);
    write_register(CfgExternalHighStart, hi_start);
    write_register(CfgExternalHighEnd, hi_end);
    write_register(CfgVideoStart, v_start);
    write_register(CfgVideoEnd, v_end);
  endtask

  // Random cycles: occasional starts, often with a low byte near the table end.
  task automatic run_random(int unsigned count, int unsigned start_odds);
    logic        start_req;
    logic [15:0] start_addr;
    repeat (count) begin
      start_req  = ($urandom_range(0, start_odds - 1) == 0);
      start_addr = 16'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        start_addr[7:0] = 8'($urandom_range(8'h90, 8'hFF));
      end
      send_cycle(start_req, start_addr, 16'($urandom));
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n         = 1'b1;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;

    // Reset settings: idle cycles, a short copy, a mirrored restart mid-copy,
    // a start whose pointer crosses into the next page, and a pending restart.
    send_cycle(1'b0, 16'h0000, 16'h0000);
    send_cycle(1'b0, 16'hFFFF, 16'hFFFF);
    send_cycle(1'b1, 16'hC09C, 16'h8000);
    send_cycle(1'b0, 16'h0000, 16'h1234);
    send_cycle(1'b0, 16'h0000, 16'h0000);
    send_cycle(1'b0, 16'h0000, 16'h8000);
    send_cycle(1'b1, 16'hE0FE, 16'hA000);
    send_cycle(1'b0, 16'h0000, 16'hFE00);
    send_cycle(1'b0, 16'h0000, 16'h9FFF);
    send_cycle(1'b0, 16'h0000, 16'hC000);
    send_cycle(1'b0, 16'h0000, 16'h7FFF);
    send_cycle(1'b1, 16'hFFFF, 16'hFDFF);
    send_cycle(1'b0, 16'h0000, 16'hE000);
    send_cycle(1'b1, 16'h8010, 16'h0001);
    send_cycle(1'b1, 16'h1050, 16'h8000);
    repeat (6) send_cycle(1'b0, 16'h0000, 16'($urandom));
    wait_for_results();

    // Every range covers the whole map and the copy starts at once.
    apply_settings(3'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_cycle(1'b1, 16'h80A0, 16'h0000);
    send_cycle(1'b0, 16'h0000, 16'hFFFF);
    send_cycle(1'b1, 16'h009E, 16'h5555);
    send_cycle(1'b0, 16'h0000, 16'hAAAA);
    run_random(80, 20);
    wait_for_results();

    // Longest countdown; the low range holds only address zero, the others are inverted.
    apply_settings(3'd7, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    send_cycle(1'b1, 16'h8000, 16'h0000);
    repeat (9) send_cycle(1'b0, 16'h0000, 16'h0000);
    run_random(40, 30);
    wait_for_results();
    run_random(40, 30);
    wait_for_results();

    // Random settings; the receiver holds off long enough to stall the input.
    apply_settings(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
    long_hold = 1'b1;
    run_random(80, 25);
    wait_for_results();
    apply_settings(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
    run_random(80, 40);
    wait_for_results();

    // Reset settings again, full throughput on both sides.
    apply_settings(StartupDelayRst, ExternalLowEndRst, ExternalHighStartRst,
                   ExternalHighEndRst, VideoStartRst, VideoEndRst);
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    run_random(100, 30);
    wait_for_results();
    repeat (8) @(posedge clk);

    if (dma_model.mismatch_count == 0) begin
      $display("** sprite_table_dma_engine: PASSED **");
    end else begin
      $display("** sprite_table_dma_engine: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sprite_table_dma_engine.f =====
sv/stdma_pkg.sv
sv/stdma_stream_if.sv
sv/stdma_bus_check.sv
sv/sprite_table_dma_engine.sv
sim/tb_top.sv
